// ----- src/assert_macros.svh -----
// Assertion macros shared by the mailbox RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bmm_pkg.sv -----
// Shared types and codes of the bounded message mailbox.
package bmm_pkg;

  localparam int unsigned MSG_LEN_W = 7;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DROP_FULL = 3'd1;
  localparam logic [2:0] ST_DROP_LONG = 3'd2;
  localparam logic [2:0] ST_FETCHED   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE    = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           out_byte;
    logic                 out_valid;
    logic                 out_last;
    logic [MSG_LEN_W-1:0] msg_length;
  } res_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic add_en;
    logic fetch_en;
    logic len_phase;
    logic stream_phase;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic len_zero;
    logic stream_last;
  } dp_status_t;

endpackage

// ----- src/bmm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bmm_ctrl.sv -----
// Controller state machine of the mailbox: accept, length lookup, byte streaming.
`include "assert_macros.svh"

module bmm_ctrl import bmm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       opcode_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LEN    = 3'b010,
    S_STREAM = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   idle;

  assign idle = (state_q == S_IDLE);

  // Decode commands for the datapath
  always_comb begin
    cmd_o.add_en       = idle && start_i && (opcode_i == OP_ADD);
    cmd_o.fetch_en     = idle && start_i && (opcode_i == OP_FETCH);
    cmd_o.len_phase    = (state_q == S_LEN);
    cmd_o.stream_phase = (state_q == S_STREAM);
  end

  assign busy_o = !idle;

  // Advance the state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.fetch_en && !status_i.empty) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        state_d = status_i.len_zero ? S_IDLE : S_STREAM;
      end
      S_STREAM: begin
        if (status_i.stream_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_fetch_enters_len, clk_i, rst_ni, cmd_o.fetch_en && !status_i.empty, state_q == S_LEN, "fetch of a nonempty queue did not start a length lookup")
  `ASSERT_ALWAYS(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "state is not one-hot")
  `ASSERT_SAME(a_no_cmd_busy, clk_i, rst_ni, busy_o, !cmd_o.add_en && !cmd_o.fetch_en, "command decoded while busy")

endmodule

// ----- src/bmm_dp.sv -----
// Datapath of the mailbox: queue pointers, message stores, add logic, result register.
`include "assert_macros.svh"

module bmm_dp import bmm_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  input  in_item_t             item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output dp_status_t           status_o,
  output res_item_t            res_o,
  output logic                 res_valid_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned LIM_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned SDEPTH = ENTRIES * SLOT_BYTES;
  localparam int unsigned AW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

  localparam logic [1:0] DISC_NONE = 2'd0;
  localparam logic [1:0] DISC_FULL = 2'd1;
  localparam logic [1:0] DISC_LONG = 2'd2;

  localparam logic [MSG_LEN_W-1:0] SLOT_LEN = MSG_LEN_W'(SLOT_BYTES);
  localparam logic [MSG_LEN_W-1:0] WO_MAX   = {MSG_LEN_W{1'b1}};

  logic [4:0]           max_entries_q;
  logic [MSG_LEN_W-1:0] max_size_q;
  logic [IDX_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [MSG_LEN_W-1:0] wo_q, wo_d;
  logic [1:0]           disc_q, disc_d;
  logic [MSG_LEN_W-1:0] len_q, len_d;
  logic [MSG_LEN_W-1:0] k_q, k_d;
  res_item_t            res_q, res_d;
  logic                 strobe_q, strobe_d;

  logic [LIM_W-1:0]     lim_entries;
  logic [MSG_LEN_W-1:0] lim_size;
  logic                 act, commit, pop, empty;
  logic [1:0]           disc_a, disc_b;
  logic [MSG_LEN_W-1:0] wo_inc;
  logic [2:0]           add_st;
  logic                 slot_we, slot_re;
  logic [AW-1:0]        slot_waddr, slot_raddr;
  logic [7:0]           slot_rdata;
  logic [MSG_LEN_W-1:0] rd_off, k_next;
  logic [MSG_LEN_W-1:0] len_rdata, len_cap;
  logic                 len_zero, stream_last;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= 5'd16;
      max_size_q    <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i[4:0];
        CFG_MAX_SIZE:    max_size_q    <= cfg_data_i[MSG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the limits to the storage
  assign lim_entries = (LIM_W'(max_entries_q) > LIM_W'(ENTRIES)) ?
                       LIM_W'(ENTRIES) : LIM_W'(max_entries_q);
  assign lim_size    = (max_size_q > SLOT_LEN) ? SLOT_LEN : max_size_q;

  // Add path: decide drop, write the byte, close the message
  assign act    = cmd_i.add_en && (item_i.byte_valid || item_i.last_byte);
  assign disc_a = ((wo_q == '0) && (disc_q == DISC_NONE) &&
                   (LIM_W'(count_q) >= lim_entries)) ? DISC_FULL : disc_q;
  assign disc_b = (item_i.byte_valid && (disc_a == DISC_NONE) && (wo_q >= lim_size)) ?
                  DISC_LONG : disc_a;
  assign wo_inc = (item_i.byte_valid && (wo_q != WO_MAX)) ? wo_q + 1'b1 : wo_q;
  assign slot_we = act && item_i.byte_valid && (disc_b == DISC_NONE) && (wo_q < SLOT_LEN);
  assign commit  = act && item_i.last_byte && (disc_b == DISC_NONE) &&
                   (count_q < CNT_W'(ENTRIES));

  always_comb begin
    if (disc_b != DISC_NONE) begin
      add_st = {1'b0, disc_b};
    end else begin
      add_st = commit ? ST_ADDED : ST_DROP_FULL;
    end
  end

  assign slot_waddr = AW'(tail_q) * AW'(SLOT_BYTES) + AW'(wo_q);

  // Fetch path: length lookup, then one byte read per cycle
  assign empty       = (count_q == '0);
  assign len_cap     = (len_rdata > SLOT_LEN) ? SLOT_LEN : len_rdata;
  assign len_zero    = (len_cap == '0);
  assign k_next      = k_q + 1'b1;
  assign stream_last = (k_next == len_q);
  assign pop         = (cmd_i.len_phase && len_zero) || (cmd_i.stream_phase && stream_last);
  assign slot_re     = (cmd_i.len_phase && !len_zero) || (cmd_i.stream_phase && !stream_last);
  assign rd_off      = cmd_i.len_phase ? '0 : k_next;
  assign slot_raddr  = AW'(head_q) * AW'(SLOT_BYTES) + AW'(rd_off);

  assign status_o.empty       = empty;
  assign status_o.len_zero    = len_zero;
  assign status_o.stream_last = stream_last;

  bmm_ram #(
    .WIDTH (8),
    .DEPTH (SDEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (item_i.data_byte),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  bmm_ram #(
    .WIDTH (MSG_LEN_W),
    .DEPTH (ENTRIES)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (tail_q),
    .wdata_i (wo_inc),
    .re_i    (cmd_i.fetch_en),
    .raddr_i (head_q),
    .rdata_o (len_rdata)
  );

  // Next state of pointers, count and open-message tracking
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    wo_d    = wo_q;
    disc_d  = disc_q;
    len_d   = len_q;
    k_d     = k_q;
    if (act) begin
      if (item_i.last_byte) begin
        wo_d   = '0;
        disc_d = DISC_NONE;
      end else begin
        wo_d   = wo_inc;
        disc_d = disc_b;
      end
    end
    if (commit) begin
      tail_d  = (tail_q == IDX_W'(ENTRIES - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (pop) begin
      head_d  = (head_q == IDX_W'(ENTRIES - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.len_phase) begin
      len_d = len_cap;
      k_d   = '0;
    end else if (cmd_i.stream_phase && !stream_last) begin
      k_d = k_next;
    end
  end

  // Build the next result transaction
  always_comb begin
    res_d    = '0;
    strobe_d = 1'b1;
    priority if (act && item_i.last_byte) begin
      res_d.status     = add_st;
      res_d.out_last   = 1'b1;
      res_d.msg_length = wo_inc;
    end else if (cmd_i.fetch_en && empty) begin
      res_d.status   = ST_EMPTY;
      res_d.out_last = 1'b1;
    end else if (cmd_i.len_phase && len_zero) begin
      res_d.status   = ST_FETCHED;
      res_d.out_last = 1'b1;
    end else if (cmd_i.stream_phase) begin
      res_d.status     = ST_FETCHED;
      res_d.out_byte   = slot_rdata;
      res_d.out_valid  = 1'b1;
      res_d.out_last   = stream_last;
      res_d.msg_length = len_q;
    end else begin
      strobe_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      wo_q     <= '0;
      disc_q   <= DISC_NONE;
      len_q    <= '0;
      k_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      wo_q     <= wo_d;
      disc_q   <= disc_d;
      len_q    <= len_d;
      k_q      <= k_d;
      strobe_q <= strobe_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = strobe_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(ENTRIES), "message count above queue depth")
  `ASSERT_SAME(a_pop_nonempty, clk_i, rst_ni, pop, count_q != '0, "message removed from an empty queue")
  `ASSERT_NEXT(a_close_result, clk_i, rst_ni, act && item_i.last_byte, res_valid_o && res_o.out_last, "closed message gave no result")

endmodule

// ----- src/bounded_message_mailbox.sv -----
// Add bytes: one per cycle, busy stays low; the closing byte's result is strobed in the next cycle.
// Fetch of an empty queue: busy stays low, result strobed on the next cycle.
// Fetch of L bytes: busy through the registered length read (an empty message ends there),
//   then one slot-memory read per byte; bytes strobe one per cycle.
// Each result is strobed for one cycle; the receiver cannot stall it.
// Reset clears pointers, count and open-message state at once; stores are not cleared.
module bounded_message_mailbox import bmm_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output res_item_t            res_o,
  output logic                 res_valid_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bmm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (cmd_i.opcode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  bmm_dp #(
    .ENTRIES    (ENTRIES),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// ----- dv/bounded_message_mailbox_tb.sv -----
// Self-checking testbench for the bounded message mailbox: directed and random traffic.
module bounded_message_mailbox_tb import bmm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES        = 16;
  localparam int unsigned SLOT_BYTES     = 64;
  localparam int unsigned HALF_PERIOD_NS = 6;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned IDLE_LIMIT     = 1000;
  // Longest fetch streams SLOT_BYTES bytes after the registered length read
  localparam int unsigned DRAIN_CYCLES   = SLOT_BYTES + 16;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             cmd_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  res_item_t            res_o;
  logic                 res_valid_o;

  bounded_message_mailbox #(
    .ENTRIES    (ENTRIES),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  always #(HALF_PERIOD_NS) clk_i = ~clk_i;

  // Mailbox prediction state
  logic [7:0]  mbox_bytes [ENTRIES*SLOT_BYTES];
  int unsigned mbox_len [ENTRIES];
  int unsigned rd_slot;
  int unsigned wr_slot;
  int unsigned held_msgs;
  int unsigned open_len;
  logic [2:0]  open_drop;
  int unsigned cfg_max_entries;
  int unsigned cfg_max_size;

  res_item_t   pending_results [$];
  res_item_t   oldest_result;
  int unsigned mismatches;
  int unsigned items_done;
  bit          no_idle;

  function automatic int unsigned wrap_slot(input int unsigned idx);
    return (idx + 1 >= ENTRIES) ? 0 : idx + 1;
  endfunction

  // Advance the mailbox state by one accepted transaction and queue its results
  function automatic void predict_mailbox(input in_item_t it);
    int unsigned lim_entries;
    int unsigned lim_size;
    int unsigned fetch_len;
    int unsigned k;
    logic [2:0]  st;
    res_item_t   r;
    lim_entries = (cfg_max_entries > ENTRIES) ? ENTRIES : cfg_max_entries;
    lim_size    = (cfg_max_size > SLOT_BYTES) ? SLOT_BYTES : cfg_max_size;
    if (it.opcode == OP_ADD) begin
      if (!it.byte_valid && !it.last_byte) return;
      // Fullness is judged once, when the message opens
      if (open_len == 0 && open_drop == ST_ADDED && held_msgs >= lim_entries)
        open_drop = ST_DROP_FULL;
      if (it.byte_valid) begin
        if (open_drop == ST_ADDED && open_len >= lim_size) open_drop = ST_DROP_LONG;
        if (open_drop == ST_ADDED && open_len < SLOT_BYTES)
          mbox_bytes[wr_slot*SLOT_BYTES + open_len] = it.data_byte;
        if (open_len < 127) open_len++;
      end
      if (!it.last_byte) return;
      st = open_drop;
      if (st == ST_ADDED) begin
        if (held_msgs < ENTRIES) begin
          mbox_len[wr_slot] = open_len;
          wr_slot = wrap_slot(wr_slot);
          held_msgs++;
        end else begin
          st = ST_DROP_FULL;
        end
      end
      r = '{status: st, out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1,
            msg_length: MSG_LEN_W'(open_len)};
      pending_results.push_back(r);
      open_len  = 0;
      open_drop = ST_ADDED;
    end else if (held_msgs == 0) begin
      r = '{status: ST_EMPTY, out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1,
            msg_length: '0};
      pending_results.push_back(r);
    end else begin
      fetch_len = (mbox_len[rd_slot] > SLOT_BYTES) ? SLOT_BYTES : mbox_len[rd_slot];
      if (fetch_len == 0) begin
        r = '{status: ST_FETCHED, out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1,
              msg_length: '0};
        pending_results.push_back(r);
      end else begin
        for (k = 0; k < fetch_len; k++) begin
          r = '{status: ST_FETCHED, out_byte: mbox_bytes[rd_slot*SLOT_BYTES + k],
                out_valid: 1'b1, out_last: (k + 1 == fetch_len),
                msg_length: MSG_LEN_W'(fetch_len)};
          pending_results.push_back(r);
        end
      end
      rd_slot = wrap_slot(rd_slot);
      held_msgs--;
    end
  endfunction

  task automatic compare_field(input string field_name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field_name, want, got);
      mismatches++;
    end
  endtask

  // Match every strobed result against the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d byte %0d len %0d",
                 $realtime, res_o.status, res_o.out_byte, res_o.msg_length);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("status", 8'(oldest_result.status), 8'(res_o.status));
        compare_field("out_byte", oldest_result.out_byte, res_o.out_byte);
        compare_field("out_valid", 8'(oldest_result.out_valid), 8'(res_o.out_valid));
        compare_field("out_last", 8'(oldest_result.out_last), 8'(res_o.out_last));
        compare_field("msg_length", 8'(oldest_result.msg_length), 8'(res_o.msg_length));
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || res_valid_o || cfg_we_i) stalled = 0;
      else stalled++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode     = 1'($urandom_range(0, 1));
    it.data_byte  = 8'($urandom_range(0, 255));
    it.byte_valid = 1'($urandom_range(0, 1));
    it.last_byte  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one transaction, with an optional idle burst first, and hold it until taken
  task automatic send_item(input in_item_t it);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      cmd_i <= random_item();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_mailbox(it);
    if (it.opcode == OP_FETCH || it.byte_valid || it.last_byte) items_done++;
  endtask

  task automatic send_add(input logic [7:0] data, input logic valid, input logic last);
    in_item_t it;
    it.opcode     = OP_ADD;
    it.data_byte  = data;
    it.byte_valid = valid;
    it.last_byte  = last;
    send_item(it);
  endtask

  task automatic send_fetch();
    in_item_t it;
    it = random_item();
    it.opcode = OP_FETCH;
    send_item(it);
  endtask

  // Add a message of n random bytes; loose mode mixes in ignored items and fetches
  task automatic send_message(input int unsigned n, input bit close_empty, input bit loose);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (loose && $urandom_range(0, 9) == 0) send_add(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (loose && $urandom_range(0, 19) == 0) send_fetch();
      send_add(8'($urandom_range(0, 255)), 1'b1, (k + 1 == n) && !close_empty);
    end
    if (n == 0 || close_empty) send_add(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Write a register once every pending result has come out
  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_ENTRIES) cfg_max_entries = value & 32'h1F;
    else cfg_max_size = value & 32'h7F;
  endtask

  task automatic test_fetch_and_add();
    send_fetch();
    send_add(8'h11, 1'b0, 1'b1);
    send_add(8'h00, 1'b1, 1'b0);
    send_add(8'h42, 1'b0, 1'b0);
    send_add(8'hFF, 1'b1, 1'b0);
    send_add(8'hA5, 1'b1, 1'b1);
    send_fetch();
    send_fetch();
    // Close a message with an item that carries no byte
    send_add(8'h5A, 1'b1, 1'b0);
    send_add(8'h3C, 1'b1, 1'b0);
    send_add(8'hC3, 1'b0, 1'b1);
    // Fetch while a message is still open
    send_add(8'h81, 1'b1, 1'b0);
    send_fetch();
    send_add(8'h7E, 1'b1, 1'b1);
    send_fetch();
    send_fetch();
  endtask

  task automatic test_size_limits();
    set_config(CFG_MAX_SIZE, 0);
    send_message(0, 1'b0, 1'b0);
    send_message(1, 1'b0, 1'b0);
    set_config(CFG_MAX_SIZE, 1);
    send_message(1, 1'b0, 1'b0);
    send_message(2, 1'b0, 1'b0);
    // Size limit above the slot acts as the slot size
    set_config(CFG_MAX_SIZE, 127);
    send_message(SLOT_BYTES + 1, 1'b0, 1'b0);
    repeat (3) send_fetch();
  endtask

  task automatic test_entry_limits();
    int unsigned k;
    set_config(CFG_MAX_ENTRIES, 0);
    send_message(0, 1'b0, 1'b0);
    send_message(2, 1'b0, 1'b0);
    send_fetch();
    set_config(CFG_MAX_ENTRIES, 1);
    set_config(CFG_MAX_SIZE, 2);
    send_message(1, 1'b0, 1'b0);
    send_message(3, 1'b0, 1'b0);
    // Full drop takes priority over an oversize message
    send_message(4, 1'b0, 1'b0);
    // Full at the first byte stays a drop after a fetch frees room
    send_add(8'h96, 1'b1, 1'b0);
    send_fetch();
    send_add(8'h69, 1'b1, 1'b1);
    send_message(2, 1'b0, 1'b0);
    send_fetch();
    set_config(CFG_MAX_ENTRIES, 31);
    set_config(CFG_MAX_SIZE, 8);
    for (k = 0; k <= ENTRIES; k++) send_message(1, 1'b0, 1'b0);
    for (k = 0; k <= ENTRIES; k++) send_fetch();
    set_config(CFG_MAX_ENTRIES, ENTRIES);
  endtask

  task automatic run_random_transaction();
    int unsigned pick;
    int unsigned len_cap;
    int unsigned n;
    pick    = $urandom_range(0, 99);
    len_cap = (cfg_max_size > SLOT_BYTES) ? SLOT_BYTES : cfg_max_size;
    if (pick < 35) begin
      send_fetch();
    end else begin
      if (pick < 85) n = $urandom_range(0, 6);
      else if (pick < 97) n = $urandom_range(0, len_cap + 2);
      else n = $urandom_range(60, 70);
      send_message(n, $urandom_range(0, 5) == 0, 1'b1);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned goal;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_config(CFG_MAX_ENTRIES, $urandom_range(1, 16));
          set_config(CFG_MAX_SIZE, $urandom_range(1, 16));
        end
        1: begin
          set_config(CFG_MAX_ENTRIES, $urandom_range(2, 4));
          set_config(CFG_MAX_SIZE, $urandom_range(1, 8));
        end
        2: begin
          set_config(CFG_MAX_ENTRIES, $urandom_range(0, 31));
          set_config(CFG_MAX_SIZE, $urandom_range(0, 127));
        end
        default: begin
          no_idle = 1'b1;
          set_config(CFG_MAX_ENTRIES, ENTRIES);
          set_config(CFG_MAX_SIZE, SLOT_BYTES);
        end
      endcase
      goal = items_done + 10;
      while (items_done < goal) run_random_transaction();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    rd_slot         = 0;
    wr_slot         = 0;
    held_msgs       = 0;
    open_len        = 0;
    open_drop       = ST_ADDED;
    cfg_max_entries = 16;
    cfg_max_size    = 64;
    mismatches      = 0;
    items_done      = 0;
    no_idle         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fetch_and_add();
    test_size_limits();
    test_entry_limits();
    test_random_traffic();

    // Drain what is still in flight
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/bmm_pkg.sv
src/bmm_ram.sv
src/bmm_ctrl.sv
src/bmm_dp.sv
src/bounded_message_mailbox.sv
dv/bounded_message_mailbox_tb.sv
